// ===== rtl/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants for the cartridge bank mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

    // ROM address widths
    localparam int PrgAddrBitsDefault = 17;
    localparam int ChrAddrBitsDefault = 17;

    localparam int DataW   = 8;
    localparam int AddrW   = 16;
    localparam int OffsetW = 17;
    localparam int NumBanks = 8;
    localparam int BankIdxW = $clog2(NumBanks);

    // request codes
    typedef enum logic [1:0] {
        CMD_CPU_WRITE = 2'd0,
        CMD_CPU_XLATE = 2'd1,
        CMD_PPU_XLATE = 2'd2
    } cbm_cmd_t;

    // mirroring codes
    localparam logic [1:0] MIRROR_BOARD = 2'd0;
    localparam logic [1:0] MIRROR_SCR_A = 2'd1;
    localparam logic [1:0] MIRROR_SCR_B = 2'd2;

    // register indexes of the config port
    localparam logic REG_VARIANT = 1'b0;

    // state update request from the translate logic
    typedef struct packed {
        logic             sel_we;
        logic             bank_we;
        logic [DataW-1:0] data;
    } cbm_wr_t;

endpackage : cbm_pkg

`default_nettype wire

// ===== rtl/cbm_regs.sv =====
// ----------------------------------------------------------------------------
// cbm_regs
// Select byte and the eight bank registers, with one bank read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_regs (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   upd_en,
    input  wire cbm_pkg::cbm_wr_t                       wr,
    input  wire logic [cbm_pkg::BankIdxW-1:0]           rd_idx,
    output logic      [cbm_pkg::DataW-1:0]              rd_data,
    output logic      [cbm_pkg::DataW-1:0]              select_reg
);
    import cbm_pkg::*;

    logic [DataW-1:0] bank_reg [NumBanks];

    // select byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            select_reg <= '0;
        end else if (upd_en && wr.sel_we) begin
            select_reg <= wr.data;
        end
    end

    // bank registers, written at the slot named by select bits 2:0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumBanks; i++) begin
                bank_reg[i] <= '1;
            end
        end else if (upd_en && wr.bank_we) begin
            bank_reg[select_reg[BankIdxW-1:0]] <= wr.data;
        end
    end

    assign rd_data = bank_reg[rd_idx];

endmodule : cbm_regs

`default_nettype wire

// ===== rtl/cbm_xlate.sv =====
// ----------------------------------------------------------------------------
// cbm_xlate
// Decode of one request: PRG/CHR offset, window hit, state update, mirroring.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_xlate #(
    parameter int PRG_ADDR_BITS = cbm_pkg::PrgAddrBitsDefault,
    parameter int CHR_ADDR_BITS = cbm_pkg::ChrAddrBitsDefault
) (
    input  wire logic [1:0]                             cmd,
    input  wire logic [cbm_pkg::AddrW-1:0]              address,
    input  wire logic [cbm_pkg::DataW-1:0]              write_data,
    input  wire logic [cbm_pkg::DataW-1:0]              select_reg,
    input  wire logic [cbm_pkg::DataW-1:0]              bank_data,
    input  wire logic                                   variant,
    output logic      [cbm_pkg::BankIdxW-1:0]           bank_idx,
    output cbm_pkg::cbm_wr_t                            wr,
    output logic      [cbm_pkg::OffsetW-1:0]            rom_offset,
    output logic                                        mapped,
    output logic      [1:0]                             mirror_mode
);
    import cbm_pkg::*;

    localparam int PrgFullW = DataW + 13;
    localparam logic [PrgFullW-1:0] PrgMask =
        PrgFullW'((64'd1 << PRG_ADDR_BITS) - 64'd1);
    localparam logic [OffsetW-1:0] ChrMask =
        OffsetW'((64'd1 << CHR_ADDR_BITS) - 64'd1);

    logic [PrgFullW-1:0] prg_full;
    logic [PrgFullW-1:0] prg_wrapped;
    logic [OffsetW-1:0]  chr_full;
    logic [13:0]         ppu_addr;
    logic [DataW-1:0]    select_next;

    assign ppu_addr = address[13:0];

    // bank slot feeding the active window
    always_comb begin
        unique case (cmd)
            CMD_CPU_XLATE: bank_idx = {2'b11, address[13]};
            CMD_PPU_XLATE: begin
                if (!ppu_addr[12]) begin
                    bank_idx = {2'b00, ppu_addr[11]};
                end else begin
                    bank_idx = BankIdxW'(3'd2 + {1'b0, ppu_addr[11:10]});
                end
            end
            default:       bank_idx = '0;
        endcase
    end

    // prg: switchable 8K windows, fixed last 16K at 0xc000
    always_comb begin
        if (address[14]) begin
            prg_full = {{(PrgFullW-14){1'b1}}, address[13:0]};
        end else begin
            prg_full = {bank_data, address[12:0]};
        end
        prg_wrapped = prg_full & PrgMask;
    end

    // chr: 2K windows from bits 5:1, 1K windows in the upper half
    always_comb begin
        if (!ppu_addr[12]) begin
            chr_full = {1'b0, bank_data[5:1], ppu_addr[10:0]};
        end else begin
            chr_full = {1'b1, bank_data[5:0], ppu_addr[9:0]};
        end
    end

    // result and state update
    always_comb begin
        wr         = '0;
        wr.data    = write_data;
        rom_offset = '0;
        mapped     = 1'b0;
        unique case (cmd)
            CMD_CPU_WRITE: begin
                if (address[15]) begin
                    wr.bank_we = address[0];
                    wr.sel_we  = !address[0];
                end
            end
            CMD_CPU_XLATE: begin
                if (address[15]) begin
                    mapped     = 1'b1;
                    rom_offset = prg_wrapped[OffsetW-1:0];
                end
            end
            CMD_PPU_XLATE: begin
                if (!ppu_addr[13]) begin
                    mapped     = 1'b1;
                    rom_offset = chr_full & ChrMask;
                end
            end
            default: begin
                mapped = 1'b0;
            end
        endcase
    end

    // mirroring follows the select byte as left by this request
    always_comb begin
        select_next = wr.sel_we ? write_data : select_reg;
        if (!variant) begin
            mirror_mode = MIRROR_BOARD;
        end else if (select_next[6]) begin
            mirror_mode = MIRROR_SCR_B;
        end else begin
            mirror_mode = MIRROR_SCR_A;
        end
    end

endmodule : cbm_xlate

`default_nettype wire

// ===== rtl/cartridge_bank_mapper_88_154.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_88_154
// Bank mapper for a cartridge board: CPU writes, PRG and CHR translation.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel (cmd, address, write_data) and each one
// gives exactly one result on the m_ channel (rom_offset, mapped,
// mirror_mode), in order. Both channels use valid/ready.
// A request is captured in an input register; when it advances, the decode
// logic updates the select/bank state and loads the result register, which
// drives m_valid. Throughput is one request per cycle while the receiver
// does not stall: the input register refills in the same cycle its request
// moves to the result register.
// When the receiver stalls, the result register holds, one more request
// waits in the input register, and s_ready then drops.
// Reset (aresetn low, synchronous) empties both registers, clears the
// select byte and the variant bit and sets all bank registers to 0xff.
// The APB port holds single_screen_variant at byte address 0; write it
// only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_mapper_88_154 #(
    parameter int PRG_ADDR_BITS = cbm_pkg::PrgAddrBitsDefault,
    parameter int CHR_ADDR_BITS = cbm_pkg::ChrAddrBitsDefault
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // config port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [2:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    // request channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_cmd,
    input  wire logic [cbm_pkg::AddrW-1:0]      s_address,
    input  wire logic [cbm_pkg::DataW-1:0]      s_write_data,
    // result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [cbm_pkg::OffsetW-1:0]         m_rom_offset,
    output logic                                m_mapped,
    output logic [1:0]                          m_mirror_mode
);
    import cbm_pkg::*;

    logic                 variant_reg;
    logic                 in_valid_reg;
    logic [1:0]           cmd_reg;
    logic [AddrW-1:0]     address_reg;
    logic [DataW-1:0]     write_data_reg;
    logic                 out_valid_reg;
    logic [OffsetW-1:0]   rom_offset_reg;
    logic                 mapped_reg;
    logic [1:0]           mirror_mode_reg;

    logic                 advance;
    logic                 cfg_we;
    logic [BankIdxW-1:0]  bank_idx;
    logic [DataW-1:0]     bank_data;
    logic [DataW-1:0]     select_reg;
    cbm_wr_t              wr;
    logic [OffsetW-1:0]   rom_offset_next;
    logic                 mapped_next;
    logic [1:0]           mirror_mode_next;

    // config register
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_VARIANT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            variant_reg <= 1'b0;
        end else if (cfg_we) begin
            variant_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_VARIANT) begin
            prdata[0] = variant_reg;
        end
    end

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg        <= s_cmd;
            address_reg    <= s_address;
            write_data_reg <= s_write_data;
        end
    end

    // mapper state
    cbm_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .upd_en     (advance),
        .wr         (wr),
        .rd_idx     (bank_idx),
        .rd_data    (bank_data),
        .select_reg (select_reg)
    );

    // request decode
    cbm_xlate #(
        .PRG_ADDR_BITS (PRG_ADDR_BITS),
        .CHR_ADDR_BITS (CHR_ADDR_BITS)
    ) u_xlate (
        .cmd         (cmd_reg),
        .address     (address_reg),
        .write_data  (write_data_reg),
        .select_reg  (select_reg),
        .bank_data   (bank_data),
        .variant     (variant_reg),
        .bank_idx    (bank_idx),
        .wr          (wr),
        .rom_offset  (rom_offset_next),
        .mapped      (mapped_next),
        .mirror_mode (mirror_mode_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rom_offset_reg  <= rom_offset_next;
            mapped_reg      <= mapped_next;
            mirror_mode_reg <= mirror_mode_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_rom_offset  = rom_offset_reg;
    assign m_mapped      = mapped_reg;
    assign m_mirror_mode = mirror_mode_reg;

endmodule : cartridge_bank_mapper_88_154

`default_nettype wire
